// ===== rtl/tmf_pkg.sv =====
// Shared constants and controller/datapath interface types for the trimmed-mean filter.
`timescale 1ns / 1ps

package tmf_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int GAIN_W         = 24;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int SUM_OUT_W      = 15;
   localparam int MA_W           = 20;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;
   localparam logic [MA_W-1:0]   MA_MAX     = 20'hFFFFF;

   typedef struct packed {
      logic load_sample;
      logic ins_read;
      logic ins_shift;
      logic ins_place;
      logic merge_init;
      logic merge_take;
      logic merge_add;
      logic mul;
      logic div;
      logic out_load;
   } tmf_cmd_type;

   typedef struct packed {
      logic ins_at_start;
      logic ins_greater;
      logic block_last;
   } tmf_status_type;

endpackage

// ===== rtl/tmf_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module tmf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== rtl/tmf_ctrl.sv =====
// Sequencer for insertion, merge, scaling and result hand-off of the trimmed-mean filter.
`timescale 1ns / 1ps

module tmf_ctrl
   import tmf_pkg::*;
#(
   parameter int BLOCK_SIZE = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output tmf_cmd_type    cmd,
   input  tmf_status_type status
);

   localparam int HALF   = BLOCK_SIZE / 2;
   localparam int LAST   = BLOCK_SIZE / 2 + BLOCK_SIZE - 1;
   localparam int STEP_N = LAST + 1;
   localparam int STEP_W = $clog2(STEP_N);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INS_CHK  = 4'd1;
   localparam logic [3:0] S_INS_CMP  = 4'd2;
   localparam logic [3:0] S_MRG_RD   = 4'd3;
   localparam logic [3:0] S_MRG_TAKE = 4'd4;
   localparam logic [3:0] S_MUL      = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_OUT      = 4'd7;

   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               state_in        = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (status.ins_at_start) begin
               cmd.ins_place = 1'b1;
               if (status.block_last) begin
                  cmd.merge_init = 1'b1;
                  step_in        = '0;
                  state_in       = S_MRG_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.ins_read = 1'b1;
               state_in     = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (status.ins_greater) begin
               cmd.ins_shift = 1'b1;
               state_in      = S_INS_CHK;
            end else begin
               cmd.ins_place = 1'b1;
               if (status.block_last) begin
                  cmd.merge_init = 1'b1;
                  step_in        = '0;
                  state_in       = S_MRG_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MRG_RD: begin
            state_in = S_MRG_TAKE;
         end
         S_MRG_TAKE: begin
            cmd.merge_take = 1'b1;
            cmd.merge_add  = (step_ff >= STEP_W'(HALF));
            if (step_ff == STEP_W'(LAST)) begin
               step_in  = '0;
               state_in = S_MUL;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_MRG_RD;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // The result register frees up in the same cycle its item is taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/tmf_dp.sv =====
// Datapath: window RAM, insertion and merge pointers, sum, gain multiply and divider.
`timescale 1ns / 1ps

module tmf_dp
   import tmf_pkg::*;
#(
   parameter int BLOCK_SIZE = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   csr_valid,
   input  logic [GAIN_W-1:0]      csr_gain_ma_q16,
   input  tmf_cmd_type            cmd,
   output tmf_status_type         status,
   output logic [SUM_OUT_W-1:0]   rsp_trimmed_sum,
   output logic [MA_W-1:0]        rsp_current_ma
);

   localparam int CNT_W     = $clog2(BLOCK_SIZE);
   localparam int PTR_W     = $clog2(BLOCK_SIZE + 1);
   localparam int ADDR_W    = $clog2(2 * BLOCK_SIZE);
   localparam int SUM_W     = SAMPLE_BITS + $clog2(BLOCK_SIZE);
   localparam int PROD_W    = SUM_W + GAIN_W;
   localparam int HI_W      = PROD_W - GAIN_FRAC_BITS;
   localparam int RCP_SHIFT = HI_W + $clog2(BLOCK_SIZE);
   localparam int RCP_W     = HI_W + 1;
   localparam int QP_W      = HI_W + RCP_W;
   localparam int Q_W       = QP_W - RCP_SHIFT;
   localparam logic [RCP_W-1:0] RCP_MUL =
      RCP_W'(((64'd1 << RCP_SHIFT) + 64'(BLOCK_SIZE - 1)) / 64'(BLOCK_SIZE));

   logic [CNT_W-1:0]       cnt_ff;
   logic                   slot_ff;
   logic                   zero_lo_ff;
   logic [GAIN_W-1:0]      gain_ff;
   logic [SAMPLE_BITS-1:0] v_ff;
   logic [CNT_W-1:0]       off_ff;
   logic [PTR_W-1:0]       lo_ff, hi_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [Q_W-1:0]         quo_ff;
   logic [SUM_OUT_W-1:0]   out_sum_ff;
   logic [MA_W-1:0]        out_ma_ff;

   logic                   fill;
   logic [ADDR_W-1:0]      fill_base, ins_addr, lo_addr, hi_addr;
   logic [ADDR_W-1:0]      wr_addr, rd_addr_a;
   logic [SAMPLE_BITS-1:0] wr_data, rd_a, rd_b, lo_val, take_val;
   logic                   wr_en, lo_done, hi_done, take_lo;
   logic [HI_W-1:0]        p_hi;
   logic [QP_W-1:0]        qprod;

   assign fill      = ~slot_ff;
   assign fill_base = fill ? ADDR_W'(BLOCK_SIZE) : '0;
   assign ins_addr  = fill_base + ADDR_W'(off_ff);

   // Exhausted halves are parked on a legal address; their data is ignored.
   assign lo_done = (lo_ff == PTR_W'(BLOCK_SIZE));
   assign hi_done = (hi_ff == PTR_W'(BLOCK_SIZE));
   assign lo_addr = lo_done ? '0 : ADDR_W'(lo_ff);
   assign hi_addr = ADDR_W'(BLOCK_SIZE) + (hi_done ? '0 : ADDR_W'(hi_ff));

   assign rd_addr_a = cmd.ins_read ? (ins_addr - 1'b1) : lo_addr;
   assign wr_en     = cmd.ins_shift || cmd.ins_place;
   assign wr_addr   = ins_addr;
   assign wr_data   = cmd.ins_shift ? rd_a : v_ff;

   tmf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (2 * BLOCK_SIZE)
   ) u_window (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (hi_addr),
      .rd_data_b (rd_b)
   );

   // Slot 0 reads as zeros until its first block has been collected.
   assign lo_val = zero_lo_ff ? '0 : rd_a;

   always_comb begin
      if (lo_done) begin
         take_lo = 1'b0;
      end else if (hi_done) begin
         take_lo = 1'b1;
      end else begin
         take_lo = (lo_val < rd_b);
      end
   end
   assign take_val = take_lo ? lo_val : rd_b;

   assign status.ins_at_start = (off_ff == '0);
   assign status.ins_greater  = (rd_a > v_ff);
   assign status.block_last   = (cnt_ff == CNT_W'(BLOCK_SIZE - 1));

   // Division by BLOCK_SIZE uses a rounded-up reciprocal, which is exact for every p_hi value.
   assign p_hi  = prod_ff[PROD_W-1:GAIN_FRAC_BITS];
   assign qprod = QP_W'(p_hi) * QP_W'(RCP_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         slot_ff    <= 1'b0;
         zero_lo_ff <= 1'b1;
         gain_ff    <= GAIN_RESET;
      end else begin
         if (csr_valid) begin
            gain_ff <= csr_gain_ma_q16;
         end
         if (cmd.ins_place) begin
            if (status.block_last) begin
               cnt_ff  <= '0;
               slot_ff <= fill;
               if (!fill) begin
                  zero_lo_ff <= 1'b0;
               end
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         v_ff   <= req_sample;
         off_ff <= cnt_ff;
      end
      if (cmd.ins_shift) begin
         off_ff <= off_ff - 1'b1;
      end
      if (cmd.merge_init) begin
         lo_ff  <= '0;
         hi_ff  <= '0;
         sum_ff <= '0;
      end
      if (cmd.merge_take) begin
         if (take_lo) begin
            lo_ff <= lo_ff + 1'b1;
         end else begin
            hi_ff <= hi_ff + 1'b1;
         end
         if (cmd.merge_add) begin
            sum_ff <= sum_ff + SUM_W'(take_val);
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(sum_ff) * PROD_W'(gain_ff);
      end
      if (cmd.div) begin
         quo_ff <= qprod[QP_W-1:RCP_SHIFT];
      end
      if (cmd.out_load) begin
         out_sum_ff <= SUM_OUT_W'(sum_ff);
         out_ma_ff  <= (quo_ff > Q_W'(MA_MAX)) ? MA_MAX : quo_ff[MA_W-1:0];
      end
   end

   assign rsp_trimmed_sum = out_sum_ff;
   assign rsp_current_ma  = out_ma_ff;

endmodule

// ===== rtl/block_trimmed_mean_filter.sv =====
// Top level of the block trimmed-mean current filter.
// Each accepted sample is insertion-sorted into the older of two BLOCK_SIZE slots of a
// window RAM; the sample moves down past every already-stored slot entry larger than it,
// and each such shift is one RAM read followed by one write. The sample that completes a
// block then starts the merge of both slots over 3*BLOCK_SIZE/2 values, each merged value
// taking a RAM read state and a take state, followed by a multiply by the gain and a
// reciprocal multiply for the division by BLOCK_SIZE; its result is then registered, later
// if the previous result is still stalled in the output register. Results wait in an output
// register while new samples are accepted. Slot 0 reads as zeros until its first block is
// in, so the first result includes it. The gain register may be written only while the
// block is idle.
`timescale 1ns / 1ps

module block_trimmed_mean_filter
   import tmf_pkg::*;
#(
   parameter int BLOCK_SIZE = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SUM_OUT_W-1:0]   rsp_trimmed_sum,
   output logic [MA_W-1:0]        rsp_current_ma,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [GAIN_W-1:0]      csr_gain_ma_q16
);

   tmf_cmd_type    cmd;
   tmf_status_type status;

   assign csr_ready = 1'b1;

   tmf_ctrl #(
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tmf_dp #(
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .csr_valid       (csr_valid && csr_ready),
      .csr_gain_ma_q16 (csr_gain_ma_q16),
      .cmd             (cmd),
      .status          (status),
      .rsp_trimmed_sum (rsp_trimmed_sum),
      .rsp_current_ma  (rsp_current_ma)
   );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the block trimmed-mean current filter.
`timescale 1ns / 1ps

module tb;
   import tmf_pkg::*;

   localparam int BLOCK       = 8;
   localparam int WIN         = 2 * BLOCK;
   localparam int SETTLE_CYC  = 100;
   localparam int DRAIN_LIMIT = 5000;

   typedef struct packed {
      logic [SUM_OUT_W-1:0] trimmed_sum;
      logic [MA_W-1:0]      current_ma;
   } filter_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SUM_OUT_W-1:0]   rsp_trimmed_sum;
   logic [MA_W-1:0]        rsp_current_ma;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [GAIN_W-1:0]      csr_gain_ma_q16 = '0;

   // Predictor state.
   logic [SAMPLE_BITS-1:0] win_store [WIN];
   logic                   last_slot;
   int unsigned            fill_count;
   logic [GAIN_W-1:0]      gain_reg;

   filter_result_type      pending_results [$];
   int                     mismatch_count = 0;
   bit                     quiet = 1'b0;
   int                     stall_left = 0;

   block_trimmed_mean_filter #(
      .BLOCK_SIZE(BLOCK)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_trimmed_sum(rsp_trimmed_sum),
      .rsp_current_ma (rsp_current_ma),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_gain_ma_q16(csr_gain_ma_q16)
   );

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stores one sample into the filling slot; a completed block is sorted, merged with the
   // other slot and the middle BLOCK values are summed and scaled.
   task automatic filter_sample(input logic [SAMPLE_BITS-1:0] s);
      int unsigned            base;
      int                     b;
      int                     lo;
      int                     hi;
      logic [SAMPLE_BITS-1:0] v;
      logic [SAMPLE_BITS-1:0] merged [WIN];
      logic [31:0]            sum;
      logic [63:0]            scaled;
      filter_result_type      res;
      base = (last_slot ? 0 : 1) * BLOCK;
      win_store[base + fill_count] = s;
      fill_count++;
      if (fill_count < BLOCK) begin
         return;
      end
      fill_count = 0;
      for (int a = 1; a < BLOCK; a++) begin
         v = win_store[base + a];
         b = a;
         while (b > 0 && win_store[base + b - 1] > v) begin
            win_store[base + b] = win_store[base + b - 1];
            b--;
         end
         win_store[base + b] = v;
      end
      last_slot = ~last_slot;
      lo = 0;
      hi = BLOCK;
      for (int k = 0; k < WIN; k++) begin
         if (lo < BLOCK && (hi >= WIN || win_store[lo] < win_store[hi])) begin
            merged[k] = win_store[lo];
            lo++;
         end else begin
            merged[k] = win_store[hi];
            hi++;
         end
      end
      sum = 0;
      for (int k = BLOCK / 2; k < BLOCK / 2 + BLOCK; k++) begin
         sum += merged[k];
      end
      scaled = (64'(sum) * 64'(gain_reg)) / (64'(BLOCK) << GAIN_FRAC_BITS);
      if (scaled > 64'(MA_MAX)) begin
         scaled = 64'(MA_MAX);
      end
      res.trimmed_sum = sum[SUM_OUT_W-1:0];
      res.current_ma  = scaled[MA_W-1:0];
      pending_results.push_back(res);
   endtask

   // Leaves valid high after acceptance; the caller either sends again or drops it
   // before time advances.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filter_sample(s);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_gain(input logic [GAIN_W-1:0] g);
      wait_idle();
      csr_valid       <= 1'b1;
      csr_gain_ma_q16 <= g;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gain_reg = g;
   endtask

   // Receiver stalls in random bursts.
   always @(posedge clock) begin
      if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 7);
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_rsp
      filter_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with no item pending: trimmed_sum %0d current_ma %0d",
                   rsp_trimmed_sum, rsp_current_ma);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_trimmed_sum !== want.trimmed_sum) begin
               $error("trimmed_sum expected %0d actual %0d", want.trimmed_sum, rsp_trimmed_sum);
               mismatch_count++;
            end
            if (rsp_current_ma !== want.current_ma) begin
               $error("current_ma expected %0d actual %0d", want.current_ma, rsp_current_ma);
               mismatch_count++;
            end
         end
      end
   end

   // The first block merges against the zero-cleared slot; then equal values, then all
   // samples at full scale for the largest sum.
   task automatic test_directed_extremes();
      logic [SAMPLE_BITS-1:0] first_block [BLOCK];
      first_block = '{12'hFFF, 12'hFFE, 12'hAAA, 12'h800, 12'h555, 12'h001, 12'h000, 12'hFFF};
      for (int i = 0; i < BLOCK; i++) begin
         send_sample(first_block[i]);
      end
      for (int i = 0; i < BLOCK; i++) begin
         send_sample(12'h800);
      end
      for (int i = 0; i < BLOCK; i++) begin
         send_sample(12'hFFF);
      end
   endtask

   // Gain extremes, each followed by a run that usually ends in a partial block.
   task automatic test_gain_settings();
      logic [GAIN_W-1:0] gains [6];
      int                n;
      gains = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000, GAIN_RESET,
                GAIN_W'($urandom_range(0, 24'hFFFFFF))};
      for (int g = 0; g < 6; g++) begin
         write_gain(gains[g]);
         n = $urandom_range(20, 60);
         for (int i = 0; i < n; i++) begin
            send_sample(SAMPLE_BITS'($urandom_range(0, 4095)));
         end
      end
   endtask

   // Runs of uniform, constant, rising, falling, low and high samples, with occasional
   // gain changes that may land in the middle of a block.
   task automatic test_random_stream(input int n_items);
      int                     sent;
      int                     len;
      int                     mode;
      int unsigned            start;
      int unsigned            step;
      logic [SAMPLE_BITS-1:0] s;
      sent = 0;
      while (sent < n_items) begin
         len   = $urandom_range(1, 16);
         mode  = $urandom_range(0, 5);
         start = $urandom_range(0, 4095);
         step  = $urandom_range(0, 300);
         for (int i = 0; i < len; i++) begin
            case (mode)
               0: s = SAMPLE_BITS'($urandom_range(0, 4095));
               1: s = SAMPLE_BITS'(start);
               2: s = SAMPLE_BITS'(start + i * step);
               3: s = SAMPLE_BITS'(start - i * step);
               4: s = SAMPLE_BITS'($urandom_range(0, 15));
               default: s = SAMPLE_BITS'($urandom_range(4080, 4095));
            endcase
            send_sample(s);
         end
         sent += len;
         if ($urandom_range(0, 29) == 0) begin
            write_gain(GAIN_W'($urandom_range(0, 24'hFFFFFF)));
         end
      end
   endtask

   task automatic test_quiet_tail();
      quiet = 1'b1;
      write_gain(GAIN_RESET);
      for (int i = 0; i < 120; i++) begin
         send_sample(SAMPLE_BITS'($urandom_range(0, 4095)));
      end
   endtask

   initial begin
      for (int i = 0; i < WIN; i++) begin
         win_store[i] = '0;
      end
      last_slot  = 1'b0;
      fill_count = 0;
      gain_reg   = GAIN_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_gain_settings();
      test_random_stream(1400);
      test_quiet_tail();

      req_valid <= 1'b0;
      for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++) begin
         @(posedge clock);
      end
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         mismatch_count++;
      end
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
